FILE: src/lbm_pkg.sv
// Shared types, constants and color functions for the LED bar meter.
// No dependencies; imported by the controller, datapath and top level.
package lbm_pkg;

	localparam int MAX_LEDS_DEF = 32;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;

	localparam logic [7:0] HUE_BASE    = 8'd205;
	localparam logic [7:0] COLOR_FULL  = 8'd255;
	localparam logic [7:0] WHEEL_SEG1  = 8'd85;
	localparam logic [7:0] WHEEL_SEG2  = 8'd170;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_LOW  = 2'd0,
		CFG_RANGE_HIGH = 2'd1,
		CFG_STRIP_LEN  = 2'd2,
		CFG_IND_EN     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic finish;
		logic emit;
	} lbm_cmd_t;

	typedef struct packed {
		logic suppress;
		logic div_done;
		logic pending;
		logic slot_free;
		logic is_last;
	} lbm_status_t;

	function automatic logic [4:0] hue_step(input logic [6:0] n);
		logic [4:0] s;
		s = 5'd0;
		if (n > 7'd60 && n <= 7'd65)      s = 5'd0;
		else if (n > 7'd55 && n <= 7'd60) s = 5'd1;
		else if (n > 7'd50 && n <= 7'd55) s = 5'd2;
		else if (n > 7'd40 && n <= 7'd50) s = 5'd3;
		else if (n > 7'd35 && n <= 7'd40) s = 5'd4;
		else if (n > 7'd24 && n <= 7'd35) s = 5'd5;
		else if (n > 7'd16 && n <= 7'd24) s = 5'd6;
		else if (n > 7'd12 && n <= 7'd16) s = 5'd8;
		else if (n > 7'd8 && n <= 7'd12)  s = 5'd12;
		else if (n > 7'd4 && n <= 7'd8)   s = 5'd16;
		return s;
	endfunction

	function automatic rgb_t wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] p3;
		rgb_t c;
		if (pos < WHEEL_SEG1) begin
			p3 = 8'(pos * 8'd3);
			c.r = p3;
			c.g = COLOR_FULL - p3;
			c.b = 8'd0;
		end else if (pos < WHEEL_SEG2) begin
			p = pos - WHEEL_SEG1;
			p3 = 8'(p * 8'd3);
			c.r = COLOR_FULL - p3;
			c.g = 8'd0;
			c.b = p3;
		end else begin
			p = pos - WHEEL_SEG2;
			p3 = 8'(p * 8'd3);
			c.r = 8'd0;
			c.g = p3;
			c.b = COLOR_FULL - p3;
		end
		return c;
	endfunction

endpackage

FILE: src/lbm_if.sv
// Valid/ready channel interfaces for readings in and pixel writes out.
// No dependencies.
interface lbm_reading_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] reading;
	logic               reading_valid;

	modport source (output valid, output reading, output reading_valid, input ready);
	modport sink   (input valid, input reading, input reading_valid, output ready);
endinterface

interface lbm_pixel_if;
	logic       valid;
	logic       ready;
	logic [4:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last;

	modport source (output valid, output pixel_index, output red, output green,
		output blue, output last, input ready);
	modport sink   (input valid, input pixel_index, input red, input green,
		input blue, input last, output ready);
endinterface

FILE: src/lbm_ctrl.sv
// Sequencing state machine for the LED bar meter: load, divide, pixel emission.
// Depends on lbm_pkg for the command and status structs.
module lbm_ctrl
	import lbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  lbm_status_t st,
	output lbm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_FINISH,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load   = in_valid;
			S_CHECK:  cmd.prep   = !st.suppress;
			S_DIV:    cmd.step   = !st.div_done;
			S_FINISH: cmd.finish = 1'b1;
			S_EMIT:   cmd.emit   = st.pending && st.slot_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= st.suppress ? S_IDLE : S_DIV;
				end
				S_DIV: begin
					if (st.div_done) state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!st.pending) state_q <= S_IDLE;
					else if (st.slot_free && st.is_last) state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/lbm_dp.sv
// Datapath: configuration registers, level scaling, serial divider,
// pixel counter, gradient color and output register. Depends on lbm_pkg.
module lbm_dp
	import lbm_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic signed [15:0]   reading,
	input  logic                 reading_valid,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [4:0]           pixel_index,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic                 last,
	input  lbm_cmd_t             cmd,
	output lbm_status_t          st
);

	localparam int CW    = $clog2(MAX_LEDS + 1);
	localparam int NUM_W = 16 + CW;
	localparam int DCW   = $clog2(NUM_W + 1);
	localparam int PW    = CW + 5;

	typedef enum logic {PH_CLEAR, PH_LIT} phase_t;

	logic signed [15:0] range_low_q;
	logic signed [15:0] range_high_q;
	logic [5:0]         strip_len_q;
	logic               ind_en_q;
	logic signed [15:0] prev_q;

	logic signed [15:0] rd_q;
	logic               suppress_q;
	logic               clear_q;
	logic [CW-1:0]      n_q;
	logic [15:0]        den_q;
	logic [4:0]         step_q;
	logic               neg_q;

	logic [NUM_W-1:0]   dvd_q;
	logic [16:0]        rem_q;
	logic [DCW-1:0]     dcnt_q;

	logic [CW-1:0]      lit_q;
	logic [CW-1:0]      pix_q;
	phase_t             phase_q;
	logic               any_q;

	logic               out_valid_q;

	logic signed [16:0] range_span;
	logic signed [16:0] diff;
	logic [NUM_W-1:0]   num;
	logic [16:0]        rem_sh;
	logic               q_bit;
	logic [CW-1:0]      lit_d;
	logic               clr_run;
	logic [CW-1:0]      pix_nx;
	logic [PW-1:0]      hue_prod;
	logic [7:0]         hue_pos;
	rgb_t               color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= 16'sd0;
			range_high_q <= 16'sd100;
			strip_len_q  <= 6'd32;
			ind_en_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RANGE_LOW:  range_low_q  <= signed'(cfg_data);
				CFG_RANGE_HIGH: range_high_q <= signed'(cfg_data);
				CFG_STRIP_LEN:  strip_len_q  <= cfg_data[5:0];
				CFG_IND_EN:     ind_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign range_span = {range_high_q[15], range_high_q} - {range_low_q[15], range_low_q};
	assign diff       = {rd_q[15], rd_q} - {range_low_q[15], range_low_q};
	assign num        = NUM_W'(diff[15:0]) * NUM_W'(n_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q       <= reading;
			suppress_q <= !reading_valid || !(range_low_q < range_high_q) || !ind_en_q;
			clear_q    <= (prev_q == 16'sd0) || (prev_q > reading);
			n_q        <= (strip_len_q > 6'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(strip_len_q);
			den_q      <= range_span[15:0];
		end
		if (cmd.prep) begin
			step_q <= hue_step(7'(n_q));
			neg_q  <= diff[16];
		end
	end

	assign rem_sh = {rem_q[15:0], dvd_q[NUM_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.prep) begin
			dcnt_q <= DCW'(NUM_W);
		end else if (cmd.step) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			dvd_q <= num;
			rem_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	always_comb begin
		if (neg_q) lit_d = '0;
		else if (dvd_q > NUM_W'(n_q)) lit_d = n_q;
		else lit_d = CW'(dvd_q);
	end

	assign clr_run = clear_q && (n_q != '0);
	assign pix_nx  = pix_q + CW'(1);

	always_comb begin
		st.suppress  = suppress_q;
		st.div_done  = (dcnt_q == '0);
		st.pending   = any_q;
		st.slot_free = !out_valid_q || out_ready;
		if (phase_q == PH_CLEAR) st.is_last = (pix_nx == n_q) && (lit_q == '0);
		else st.is_last = (pix_nx == lit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 16'sd0;
			any_q  <= 1'b0;
		end else begin
			if (cmd.finish) begin
				prev_q <= rd_q;
				any_q  <= clr_run || (lit_d != '0);
			end else if (cmd.emit && st.is_last) begin
				any_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			lit_q   <= lit_d;
			pix_q   <= '0;
			phase_q <= clr_run ? PH_CLEAR : PH_LIT;
		end else if (cmd.emit) begin
			if (phase_q == PH_CLEAR && pix_nx == n_q) begin
				phase_q <= PH_LIT;
				pix_q   <= '0;
			end else begin
				pix_q <= pix_nx;
			end
		end
	end

	assign hue_prod = PW'(pix_q) * PW'(step_q);
	assign hue_pos  = 8'(hue_prod) + HUE_BASE;
	assign color    = (phase_q == PH_CLEAR) ? rgb_t'('0) : wheel(hue_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_index <= 5'(pix_q);
			red         <= color.r;
			green       <= color.g;
			blue        <= color.b;
			last        <= st.is_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/led_bar_meter_gradient.sv
// Top level of the LED bar meter: joins the controller and the datapath.
// Depends on lbm_pkg, lbm_if, lbm_ctrl and lbm_dp.
//
// One reading is taken at a time. A suppressed reading (no value, empty
// range or indication off) frees the input right after the check. A
// displayed reading goes through setup and serial division of a
// (16 + clog2(MAX_LEDS+1))-bit dividend, 22 bits at MAX_LEDS = 32, by the
// restoring divider, and then writes one pixel per cycle while the output
// is taken: up to MAX_LEDS black pixels when the strip is cleared, then the
// lit pixels, last marking the final write. The input is ready again as
// soon as the final pixel sits in the output register, or after division
// when no pixel is to be written.
module led_bar_meter_gradient
	import lbm_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	lbm_reading_if.sink          reading_ch,
	lbm_pixel_if.source          pixel_ch
);

	lbm_cmd_t    cmd;
	lbm_status_t st;

	lbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (reading_ch.valid),
		.in_ready (reading_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	lbm_dp #(
		.MAX_LEDS (MAX_LEDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.reading       (reading_ch.reading),
		.reading_valid (reading_ch.reading_valid),
		.out_ready     (pixel_ch.ready),
		.out_valid     (pixel_ch.valid),
		.pixel_index   (pixel_ch.pixel_index),
		.red           (pixel_ch.red),
		.green         (pixel_ch.green),
		.blue          (pixel_ch.blue),
		.last          (pixel_ch.last),
		.cmd           (cmd),
		.st            (st)
	);

endmodule

FILE: src/lbm_chk.sv
// Port-level checker for the LED bar meter and its bind to the top level.
// Depends on led_bar_meter_gradient and lbm_pkg.
module lbm_chk
	import lbm_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] pixel_index,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last))
		else $error("stalled pixel request changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready right after an accepted reading");

	a_no_early_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("pixel request before setup finished");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(pixel_index) < MAX_LEDS))
		else $error("pixel index beyond strip");

endmodule

bind led_bar_meter_gradient lbm_chk #(
	.MAX_LEDS (MAX_LEDS)
) u_lbm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (reading_ch.valid),
	.in_ready    (reading_ch.ready),
	.out_valid   (pixel_ch.valid),
	.out_ready   (pixel_ch.ready),
	.pixel_index (pixel_ch.pixel_index),
	.red         (pixel_ch.red),
	.green       (pixel_ch.green),
	.blue        (pixel_ch.blue),
	.last        (pixel_ch.last)
);
